@@ rtl/core/hp_pkg.sv @@
// Shared constants for the histogram percentile block.
package hp_pkg;

  // Width of one bin count and of the masked pixel total.
  localparam int CNT_W = 21;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Percentile fraction register, unsigned Q1.16 with one integer bit.
  localparam int FRAC_W = 17;
  localparam int FRAC_SHIFT = 16;
  localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(65536);
  localparam logic [FRAC_W-1:0] FRAC_RESET = FRAC_W'(32768);

  // Target product width.
  localparam int TGT_W = CNT_W + FRAC_W;

  // Sample and result widths.
  localparam int PIX_W = 8;
  localparam int RES_W = 8;

  // Configuration port.
  localparam int APB_DW = 32;
  localparam int APB_AW = 2;
  localparam logic [APB_AW-1:0] REG_FRACTION = 2'd0;

  localparam int NUM_BINS_DEF = 256;

endpackage

@@ rtl/core/histogram_percentile.sv @@
// Masked 8-bit histogram with a percentile search over the bins.
//
// Flow: an unmasked item that is not last is accepted and busy
// stays low; a masked item holds busy for the bin read-modify-write.
// On the last item the block forms the target, then scans NUM_BINS bins at one
// bin per cycle; done rises when the scan of the last bin ends.
// Reset: synchronous; a clearing pass zeroes the bin memory, with busy high.
// The result is a one-cycle strobe; the receiver cannot stall it.
module histogram_percentile #(
  parameter int NUM_BINS = hp_pkg::NUM_BINS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // Pixel command channel.
  input  logic                        start,
  output logic                        busy,
  input  logic [hp_pkg::PIX_W-1:0]    pixel_value,
  input  logic                        in_mask,
  input  logic                        last_pixel,
  // Result channel.
  output logic                        done,
  output logic [hp_pkg::RES_W-1:0]    percentile_value,
  // Configuration port.
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hp_pkg::APB_AW-1:0]   paddr,
  input  logic [hp_pkg::APB_DW-1:0]   pwdata,
  output logic [hp_pkg::APB_DW-1:0]   prdata,
  output logic                        pready
);
  import hp_pkg::*;

  localparam int BIN_W = $clog2(NUM_BINS);
  localparam int PW    = PIX_W + BIN_W + 1;
  localparam int RUN_W = CNT_W + BIN_W;
  localparam int CMP_W = RUN_W + FRAC_SHIFT;
  localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(NUM_BINS - 1);

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_UPD,
    ST_TGT,
    ST_SCAN
  } state_t;

  state_t state;

  // Bin memory: one write port, one registered read port.
  logic [CNT_W-1:0] mem [NUM_BINS];
  logic             mem_we;
  logic [BIN_W-1:0] mem_wa;
  logic [CNT_W-1:0] mem_wd;
  logic [BIN_W-1:0] mem_ra;
  logic [CNT_W-1:0] rd_data;

  logic [FRAC_W-1:0] fraction;
  logic [CNT_W-1:0]  masked_total;
  logic [TGT_W-1:0]  target;
  logic [BIN_W-1:0]  idx;       // clearing pointer, then index of the bin in rd_data
  logic [BIN_W-1:0]  upd_bin;   // bin of the pixel under update
  logic              upd_last;
  logic [RUN_W-1:0]  run;
  logic              found;
  logic [BIN_W-1:0]  hit_idx;

  logic              accept;
  logic              cfg_wr;
  logic [PW-1:0]     bin_prod;
  logic [BIN_W:0]    bin_raw;
  logic [BIN_W-1:0]  pix_bin;
  logic [FRAC_W-1:0] frac_c;
  logic [RUN_W-1:0]  run_sum;
  logic              hit;
  logic [BIN_W-1:0]  pick;
  logic [BIN_W+RES_W-1:0] pick_wide;
  logic [RES_W-1:0]  pick_sat;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr == REG_FRACTION) ? APB_DW'(fraction) : '0;

  // Pixel value v lands in bin (v * NUM_BINS) >> 8, kept inside the table.
  assign bin_prod = PW'(pixel_value) * PW'(NUM_BINS);
  assign bin_raw  = bin_prod[PW-1:PIX_W];
  assign pix_bin  = (bin_raw >= (BIN_W+1)'(NUM_BINS)) ? LAST_BIN : bin_raw[BIN_W-1:0];

  // A fraction above one is treated as exactly one.
  assign frac_c = fraction[FRAC_W-1] ? FRAC_ONE : fraction;

  // One add and one compare per scanned bin.
  assign run_sum = run + RUN_W'(rd_data);
  assign hit     = !found && ({run_sum, {FRAC_SHIFT{1'b0}}} >= CMP_W'(target));

  // If the running sum never reaches the target, the last bin is reported.
  assign pick      = found ? hit_idx : (hit ? idx : LAST_BIN);
  assign pick_wide = (BIN_W+RES_W)'(pick);
  assign pick_sat  = (pick_wide > (BIN_W+RES_W)'(255)) ? {RES_W{1'b1}} : pick_wide[RES_W-1:0];

  // Memory port steering. The scan zeroes each bin right after reading it.
  always_comb begin
    mem_we = 1'b0;
    mem_wa = idx;
    mem_wd = '0;
    mem_ra = pix_bin;
    unique case (state)
      ST_CLR: begin
        mem_we = 1'b1;
      end
      ST_IDLE: begin
        mem_ra = pix_bin;
      end
      ST_UPD: begin
        mem_we = 1'b1;
        mem_wa = upd_bin;
        mem_wd = (rd_data == CNT_MAX) ? CNT_MAX : rd_data + 1'b1;
      end
      ST_TGT: begin
        mem_ra = '0;
      end
      ST_SCAN: begin
        mem_we = 1'b1;
        mem_ra = idx + 1'b1;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data <= mem[mem_ra];
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      fraction <= FRAC_RESET;
    end else if (cfg_wr && (paddr == REG_FRACTION)) begin
      fraction <= pwdata[FRAC_W-1:0];
    end
  end

  // Sequencer: reset clear, update, target, scan with clear-behind, result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_CLR;
      idx              <= '0;
      masked_total     <= '0;
      done             <= 1'b0;
      found            <= 1'b0;
      upd_last         <= 1'b0;
      percentile_value <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_CLR: begin
          idx <= idx + 1'b1;
          if (idx == LAST_BIN) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            upd_bin  <= pix_bin;
            upd_last <= last_pixel;
            if (in_mask && masked_total != CNT_MAX) begin
              masked_total <= masked_total + 1'b1;
            end
            if (in_mask) begin
              state <= ST_UPD;
            end else if (last_pixel) begin
              state <= ST_TGT;
            end
          end
        end
        ST_UPD: begin
          state <= upd_last ? ST_TGT : ST_IDLE;
        end
        ST_TGT: begin
          target <= TGT_W'(masked_total) * TGT_W'(frac_c);
          run    <= '0;
          found  <= 1'b0;
          idx    <= '0;
          state  <= ST_SCAN;
        end
        ST_SCAN: begin
          run <= run_sum;
          idx <= idx + 1'b1;
          if (hit) begin
            found   <= 1'b1;
            hit_idx <= idx;
          end
          if (idx == LAST_BIN) begin
            done             <= 1'b1;
            percentile_value <= pick_sat;
            masked_total     <= '0;
            state            <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // A result only ever follows the final cycle of a scan.
  a_done_after_scan: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_SCAN))
    else $error("result strobe without a completed scan");

  // The pixel total is cleared together with the result.
  a_total_cleared: assert property (@(posedge clk) disable iff (rst)
    done |-> (masked_total == '0))
    else $error("masked total not cleared with the result");

  // A masked beat always holds the block for its bin update.
  a_masked_holds: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && in_mask) |=> (busy && state == ST_UPD))
    else $error("masked beat did not start a bin update");

  // Once the bin is found during a scan, it is not replaced.
  a_hit_stable: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && found) |=> $stable(hit_idx))
    else $error("found bin index changed during scan");

endmodule
